>>> rtl/assert_macros.svh
// Assertion helpers; every user provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QPRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qpre_pkg.sv
package qpre_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QZERO  = 2'd1,
    ST_ZDEPTH = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_e;

  localparam int ROT_QW = 29;
  localparam int PRJ_QW = 41;
  localparam logic [PRJ_QW-1:0] PROJ_CLAMP = {1'b1, {(PRJ_QW-1){1'b0}}};
  localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

endpackage

>>> rtl/quaternion_pinhole_reprojection_error.sv
// Channel   Dir  Width  Contents
// s_axis    in   320    quat_w/x/y/z, trans_x/y/z, point_x/y/z, seen_x/y
// m_axis    out  64+2   resid_x, resid_y; tuser = status
// cfg       in   2+32   focal_x, focal_y, center_x, center_y
// One request per cycle while the output is not stalled; 82 register stages, with
// the 29-step rotation divider and the 41-step projection divider, one quotient bit
// per stage.
// Reset clears all valid bits and restores the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped.
module quaternion_pinhole_reprojection_error
  import qpre_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
  // point_x, point_y, point_z, seen_x, seen_y
  input  logic [319:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // resid_x, resid_y
  output logic [63:0]  m_axis_tdata_o,
  // status
  output logic [1:0]   m_axis_tuser_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  typedef struct packed {
    logic [32:0] rem;
    logic [ROT_QW-1:0] qd;
    logic neg;
  } rlane_t;

  typedef struct packed {
    logic [62:0] rem;
    logic [PRJ_QW-1:0] qd;
    logic ovf;
  } plane_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } seen_t;

  typedef struct packed {
    logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [32:0] dx, dy, dz;
    seen_t seen;
  } a_t;

  typedef struct packed {
    logic [32:0] n2;
    logic [8:0][32:0] mag;
    logic [8:0] neg;
    logic [32:0] dx, dy, dz;
    seen_t seen;
  } b_t;

  typedef struct packed {
    rlane_t [8:0] lane;
    logic [32:0] n2;
    logic qzero;
    logic [32:0] dx, dy, dz;
    seen_t seen;
  } rot_t;

  typedef struct packed {
    logic [8:0][29:0] r;
    logic qzero;
    logic [32:0] dx, dy, dz;
    seen_t seen;
  } e_t;

  typedef struct packed {
    logic [8:0][62:0] p;
    logic qzero;
    seen_t seen;
  } f_t;

  typedef struct packed {
    logic [63:0] xc, yc, zc;
    logic qzero;
    seen_t seen;
  } g_t;

  typedef struct packed {
    logic [62:0] magx, magy, den;
    logic [1:0] neg;
    logic zzero;
    logic qzero;
    seen_t seen;
  } h_t;

  typedef struct packed {
    logic [63:0] pxl, pyl;
    logic [62:0] pxh, pyh;
    logic [62:0] den;
    logic [1:0] neg;
    logic zzero;
    logic qzero;
    seen_t seen;
  } i_t;

  typedef struct packed {
    logic [95:0] nx, ny;
    logic [62:0] den;
    logic [1:0] neg;
    logic zzero;
    logic qzero;
    seen_t seen;
  } j_t;

  typedef struct packed {
    plane_t [1:0] lane;
    logic [62:0] den;
    logic [1:0] neg;
    logic zzero;
    logic qzero;
    seen_t seen;
  } prj_t;

  typedef struct packed {
    logic [41:0] px, py;
    logic zzero;
    logic qzero;
    seen_t seen;
  } l_t;

  function automatic rlane_t rot_step(rlane_t l, logic [32:0] n2);
    logic [33:0] trial;
    rlane_t r;
    trial = {l.rem, l.qd[ROT_QW-1]};
    r = l;
    if (trial >= {1'b0, n2}) begin
      r.rem = 33'(trial - {1'b0, n2});
      r.qd = {l.qd[ROT_QW-2:0], 1'b1};
    end else begin
      r.rem = trial[32:0];
      r.qd = {l.qd[ROT_QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic plane_t prj_step(plane_t l, logic [62:0] den);
    logic [63:0] trial;
    plane_t r;
    trial = {l.rem, l.qd[PRJ_QW-1]};
    r = l;
    if (trial >= {1'b0, den}) begin
      r.rem = 63'(trial - {1'b0, den});
      r.qd = {l.qd[PRJ_QW-2:0], 1'b1};
    end else begin
      r.rem = trial[62:0];
      r.qd = {l.qd[PRJ_QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [33:0] sx34(logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic [41:0] proj_val(plane_t l, logic neg);
    logic [PRJ_QW-1:0] q;
    q = (l.ovf || l.qd > PROJ_CLAMP) ? PROJ_CLAMP : l.qd;
    return neg ? 42'(-{1'b0, q}) : {1'b0, q};
  endfunction

  function automatic logic [42:0] resid_sum(logic [41:0] p, logic [31:0] c, logic [31:0] s);
    return {p[41], p} + {{11{c[31]}}, c} - {{11{s[31]}}, s};
  endfunction

  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

  logic adv;

  a_t a_d, a_q;
  b_t b_d, b_q;
  rot_t rot_d [ROT_QW+1];
  rot_t rot_q [ROT_QW+1];
  e_t e_d, e_q;
  f_t f_d, f_q;
  g_t g_d, g_q;
  h_t h_d, h_q;
  i_t i_d, i_q;
  j_t j_d, j_q;
  prj_t prj_d [PRJ_QW+1];
  prj_t prj_q [PRJ_QW+1];
  l_t l_d, l_q;
  logic [63:0] tdata_d, tdata_q;
  logic [1:0] tuser_d, tuser_q;

  logic a_v_q, b_v_q, e_v_q, f_v_q, g_v_q, h_v_q, i_v_q, j_v_q, l_v_q, o_v_q;
  logic [ROT_QW:0] rot_v_q;
  logic [PRJ_QW:0] prj_v_q;

  assign adv = !o_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = o_v_q;
  assign m_axis_tdata_o = tdata_q;
  assign m_axis_tuser_o = tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_RESET;
      focal_y_q  <= FOCAL_RESET;
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
      endcase
    end
  end

  // products of the quaternion and the point offset
  always_comb begin
    logic signed [15:0] qw, qx, qy, qz;
    logic [31:0] tx, ty, tz, px, py, pz;
    qw = s_axis_tdata_i[15:0];
    qx = s_axis_tdata_i[31:16];
    qy = s_axis_tdata_i[47:32];
    qz = s_axis_tdata_i[63:48];
    tx = s_axis_tdata_i[95:64];
    ty = s_axis_tdata_i[127:96];
    tz = s_axis_tdata_i[159:128];
    px = s_axis_tdata_i[191:160];
    py = s_axis_tdata_i[223:192];
    pz = s_axis_tdata_i[255:224];
    a_d.ww = qw * qw;
    a_d.xx = qx * qx;
    a_d.yy = qy * qy;
    a_d.zz = qz * qz;
    a_d.xy = qx * qy;
    a_d.wz = qw * qz;
    a_d.xz = qx * qz;
    a_d.wy = qw * qy;
    a_d.yz = qy * qz;
    a_d.wx = qw * qx;
    a_d.dx = {px[31], px} - {tx[31], tx};
    a_d.dy = {py[31], py} - {ty[31], ty};
    a_d.dz = {pz[31], pz} - {tz[31], tz};
    a_d.seen.x = s_axis_tdata_i[287:256];
    a_d.seen.y = s_axis_tdata_i[319:288];
  end

  // norm and rotation numerators
  always_comb begin
    logic [33:0] num [9];
    num[0] = sx34(a_q.ww) + sx34(a_q.xx) - sx34(a_q.yy) - sx34(a_q.zz);
    num[1] = 34'((sx34(a_q.xy) - sx34(a_q.wz)) << 1);
    num[2] = 34'((sx34(a_q.xz) + sx34(a_q.wy)) << 1);
    num[3] = 34'((sx34(a_q.xy) + sx34(a_q.wz)) << 1);
    num[4] = sx34(a_q.ww) - sx34(a_q.xx) + sx34(a_q.yy) - sx34(a_q.zz);
    num[5] = 34'((sx34(a_q.yz) - sx34(a_q.wx)) << 1);
    num[6] = 34'((sx34(a_q.xz) - sx34(a_q.wy)) << 1);
    num[7] = 34'((sx34(a_q.yz) + sx34(a_q.wx)) << 1);
    num[8] = sx34(a_q.ww) - sx34(a_q.xx) - sx34(a_q.yy) + sx34(a_q.zz);
    b_d.n2 = 33'(a_q.ww) + 33'(a_q.xx) + 33'(a_q.yy) + 33'(a_q.zz);
    for (int k = 0; k < 9; k++) begin
      b_d.neg[k] = num[k][33];
      b_d.mag[k] = num[k][33] ? 33'(-num[k]) : num[k][32:0];
    end
    b_d.dx = a_q.dx;
    b_d.dy = a_q.dy;
    b_d.dz = a_q.dz;
    b_d.seen = a_q.seen;
  end

  // rotation divider: load, then one quotient bit per stage
  always_comb begin
    logic [61:0] dvd;
    for (int k = 0; k < 9; k++) begin
      dvd = {1'b0, b_q.mag[k], 28'b0} + 62'(b_q.n2 >> 1);
      rot_d[0].lane[k].rem = dvd[61:ROT_QW];
      rot_d[0].lane[k].qd = dvd[ROT_QW-1:0];
      rot_d[0].lane[k].neg = b_q.neg[k];
    end
    rot_d[0].n2 = b_q.n2;
    rot_d[0].qzero = (b_q.n2 == '0);
    rot_d[0].dx = b_q.dx;
    rot_d[0].dy = b_q.dy;
    rot_d[0].dz = b_q.dz;
    rot_d[0].seen = b_q.seen;
    for (int s = 1; s <= ROT_QW; s++) begin
      rot_d[s] = rot_q[s-1];
      for (int k = 0; k < 9; k++) begin
        rot_d[s].lane[k] = rot_step(rot_q[s-1].lane[k], rot_q[s-1].n2);
      end
    end
  end

  // signed rotation entries
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e_d.r[k] = rot_q[ROT_QW].lane[k].neg ? 30'(-{1'b0, rot_q[ROT_QW].lane[k].qd})
                                            : {1'b0, rot_q[ROT_QW].lane[k].qd};
    end
    e_d.qzero = rot_q[ROT_QW].qzero;
    e_d.dx = rot_q[ROT_QW].dx;
    e_d.dy = rot_q[ROT_QW].dy;
    e_d.dz = rot_q[ROT_QW].dz;
    e_d.seen = rot_q[ROT_QW].seen;
  end

  // R^T (P - t) products
  always_comb begin
    logic signed [62:0] pk;
    logic signed [32:0] dsel;
    for (int k = 0; k < 9; k++) begin
      dsel = (k < 3) ? e_q.dx : ((k < 6) ? e_q.dy : e_q.dz);
      pk = $signed(e_q.r[k]) * dsel;
      f_d.p[k] = pk;
    end
    f_d.qzero = e_q.qzero;
    f_d.seen = e_q.seen;
  end

  always_comb begin
    logic signed [63:0] s0, s1, s2;
    s0 = 64'($signed(f_q.p[0])) + 64'($signed(f_q.p[3])) + 64'($signed(f_q.p[6]));
    s1 = 64'($signed(f_q.p[1])) + 64'($signed(f_q.p[4])) + 64'($signed(f_q.p[7]));
    s2 = 64'($signed(f_q.p[2])) + 64'($signed(f_q.p[5])) + 64'($signed(f_q.p[8]));
    g_d.xc = s0;
    g_d.yc = s1;
    g_d.zc = s2;
    g_d.qzero = f_q.qzero;
    g_d.seen = f_q.seen;
  end

  always_comb begin
    h_d.magx = g_q.xc[63] ? 63'(-g_q.xc) : g_q.xc[62:0];
    h_d.magy = g_q.yc[63] ? 63'(-g_q.yc) : g_q.yc[62:0];
    h_d.den = g_q.zc[63] ? 63'(-g_q.zc) : g_q.zc[62:0];
    h_d.neg[0] = g_q.xc[63] ^ g_q.zc[63];
    h_d.neg[1] = g_q.yc[63] ^ g_q.zc[63];
    h_d.zzero = (g_q.zc == '0);
    h_d.qzero = g_q.qzero;
    h_d.seen = g_q.seen;
  end

  // focal length times depth-free coordinate, split into halves
  always_comb begin
    logic [63:0] xl, yl;
    logic [62:0] xh, yh;
    xl = focal_x_q * h_q.magx[31:0];
    yl = focal_y_q * h_q.magy[31:0];
    xh = focal_x_q * h_q.magx[62:32];
    yh = focal_y_q * h_q.magy[62:32];
    i_d.pxl = xl;
    i_d.pyl = yl;
    i_d.pxh = xh;
    i_d.pyh = yh;
    i_d.den = h_q.den;
    i_d.neg = h_q.neg;
    i_d.zzero = h_q.zzero;
    i_d.qzero = h_q.qzero;
    i_d.seen = h_q.seen;
  end

  always_comb begin
    j_d.nx = {1'b0, i_q.pxh, 32'b0} + {32'b0, i_q.pxl} + {34'b0, i_q.den[62:1]};
    j_d.ny = {1'b0, i_q.pyh, 32'b0} + {32'b0, i_q.pyl} + {34'b0, i_q.den[62:1]};
    j_d.den = i_q.den;
    j_d.neg = i_q.neg;
    j_d.zzero = i_q.zzero;
    j_d.qzero = i_q.qzero;
    j_d.seen = i_q.seen;
  end

  // projection divider
  always_comb begin
    prj_d[0].lane[0].rem = {8'b0, j_q.nx[95:PRJ_QW]};
    prj_d[0].lane[0].qd = j_q.nx[PRJ_QW-1:0];
    prj_d[0].lane[0].ovf = ({8'b0, j_q.nx[95:PRJ_QW]} >= j_q.den);
    prj_d[0].lane[1].rem = {8'b0, j_q.ny[95:PRJ_QW]};
    prj_d[0].lane[1].qd = j_q.ny[PRJ_QW-1:0];
    prj_d[0].lane[1].ovf = ({8'b0, j_q.ny[95:PRJ_QW]} >= j_q.den);
    prj_d[0].den = j_q.den;
    prj_d[0].neg = j_q.neg;
    prj_d[0].zzero = j_q.zzero;
    prj_d[0].qzero = j_q.qzero;
    prj_d[0].seen = j_q.seen;
    for (int s = 1; s <= PRJ_QW; s++) begin
      prj_d[s] = prj_q[s-1];
      for (int k = 0; k < 2; k++) begin
        prj_d[s].lane[k] = prj_step(prj_q[s-1].lane[k], prj_q[s-1].den);
      end
    end
  end

  always_comb begin
    l_d.px = proj_val(prj_q[PRJ_QW].lane[0], prj_q[PRJ_QW].neg[0]);
    l_d.py = proj_val(prj_q[PRJ_QW].lane[1], prj_q[PRJ_QW].neg[1]);
    l_d.zzero = prj_q[PRJ_QW].zzero;
    l_d.qzero = prj_q[PRJ_QW].qzero;
    l_d.seen = prj_q[PRJ_QW].seen;
  end

  // residuals, saturation and status
  always_comb begin
    logic [42:0] rx, ry;
    logic satx, saty;
    logic [31:0] ox, oy;
    rx = resid_sum(l_q.px, center_x_q, l_q.seen.x);
    ry = resid_sum(l_q.py, center_y_q, l_q.seen.y);
    satx = (rx[42:31] != '0) && (rx[42:31] != '1);
    saty = (ry[42:31] != '0) && (ry[42:31] != '1);
    ox = satx ? (rx[42] ? 32'h8000_0000 : 32'h7fff_ffff) : rx[31:0];
    oy = saty ? (ry[42] ? 32'h8000_0000 : 32'h7fff_ffff) : ry[31:0];
    priority if (l_q.qzero) begin
      tdata_d = '0;
      tuser_d = ST_QZERO;
    end else if (l_q.zzero) begin
      tdata_d = '0;
      tuser_d = ST_ZDEPTH;
    end else begin
      tdata_d = {oy, ox};
      tuser_d = (satx || saty) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      rot_v_q <= '0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      prj_v_q <= '0;
      l_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= s_axis_tvalid_i;
      b_v_q <= a_v_q;
      rot_v_q <= {rot_v_q[ROT_QW-1:0], b_v_q};
      e_v_q <= rot_v_q[ROT_QW];
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
      prj_v_q <= {prj_v_q[PRJ_QW-1:0], j_v_q};
      l_v_q <= prj_v_q[PRJ_QW];
      o_v_q <= l_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
      b_q <= b_d;
      for (int s = 0; s <= ROT_QW; s++) begin
        rot_q[s] <= rot_d[s];
      end
      e_q <= e_d;
      f_q <= f_d;
      g_q <= g_d;
      h_q <= h_d;
      i_q <= i_d;
      j_q <= j_d;
      for (int s = 0; s <= PRJ_QW; s++) begin
        prj_q[s] <= prj_d[s];
      end
      l_q <= l_d;
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

endmodule

>>> rtl/qpre_chk.sv
`include "assert_macros.svh"

module qpre_chk
  import qpre_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  logic err_code;
  logic rail_hit;

  assign err_code = (m_axis_tuser_o == ST_QZERO) || (m_axis_tuser_o == ST_ZDEPTH);
  assign rail_hit = (m_axis_tdata_o[31:0] == 32'h7fff_ffff) ||
                    (m_axis_tdata_o[31:0] == 32'h8000_0000) ||
                    (m_axis_tdata_o[63:32] == 32'h7fff_ffff) ||
                    (m_axis_tdata_o[63:32] == 32'h8000_0000);

  `QPRE_ASSERT_NOW(a_err_zero, m_axis_tvalid_o && err_code, m_axis_tdata_o == '0, "error result with nonzero residual")
  `QPRE_ASSERT_NOW(a_sat_rail, m_axis_tvalid_o && (m_axis_tuser_o == ST_SAT), rail_hit, "saturation flagged off the rails")
  `QPRE_ASSERT_NOW(a_idle_ready, !m_axis_tvalid_o, s_axis_tready_o, "input blocked with empty output")
  `QPRE_ASSERT_NEXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind quaternion_pinhole_reprojection_error qpre_chk u_qpre_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
